>>> hw/rtl/segment_box_intercept_core_assert.svh
// ----------------------------------------------------------------------------
// Segment box intercept assertion macros
// Assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_INTERCEPT_CORE_ASSERT_SVH
`define SEGMENT_BOX_INTERCEPT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SBI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SBI_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");
`else
`define SBI_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SBI_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

>>> hw/rtl/sbi_pkg.sv
// ----------------------------------------------------------------------------
// Segment box intercept package
// Face codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbi_pkg;

	typedef enum logic [2:0] {
		FACE_MIN_X = 3'd0,
		FACE_MAX_X = 3'd1,
		FACE_MIN_Y = 3'd2,
		FACE_MAX_Y = 3'd3,
		FACE_MIN_Z = 3'd4,
		FACE_MAX_Z = 3'd5
	} face_t;

	localparam int FACE_COUNT = 6;

	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	typedef struct packed {
		logic  ok;
		face_t face;
	} pick_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbi_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring divide, one quotient bit per stage, round half up at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbi_div #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [2*W-1:0] num,
	input  logic [W-1:0]   den,
	output logic [W:0]     quo
);

	logic [W-1:0] rem_s [W];
	logic [W-1:0] acc_s [W];
	logic [W-1:0] den_s [W];

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [W-1:0] rem_in;
		logic [W-1:0] acc_in;
		logic [W-1:0] den_in;
		logic [W:0]   trial;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_in = num[2*W-1:W];
			assign acc_in = num[W-1:0];
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign acc_in = acc_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign trial = {rem_in, acc_in[W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
			acc_s[k] <= {acc_in[W-2:0], ge};
			den_s[k] <= den_in;
		end
	end

	always_ff @(posedge clk) begin
		quo <= {1'b0, acc_s[W-1]}
			+ (W+1)'({rem_s[W-1], 1'b0} >= {1'b0, den_s[W-1]});
	end

endmodule

`default_nettype wire

>>> hw/rtl/sbi_face.sv
// ----------------------------------------------------------------------------
// Face crossing unit
// Crossing test, interpolation, bounds check and squared distance for one face.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbi_face import sbi_pkg::*; #(
	parameter int W     = 32,
	parameter int AXIS  = 0,
	parameter bit UPPER = 1'b0
) (
	input  logic                 clk,
	input  logic [2:0][W-1:0]    seg_s,
	input  logic [2:0][W-1:0]    seg_e,
	input  logic [2:0][W-1:0]    box_lo,
	input  logic [2:0][W-1:0]    box_hi,
	output logic                 cand_ok,
	output logic [2*W+1:0]       cand_dist,
	output logic [2:0][W-1:0]    cand_pnt
);

	localparam int B0      = (AXIS + 1) % 3;
	localparam int B1      = (AXIS + 2) % 3;
	localparam int DIV_LAT = W + 1;

	logic [W-1:0] plane;
	assign plane = UPPER ? box_hi[AXIS] : box_lo[AXIS];

	logic signed [W:0] d_s1, n_s1, del0_s1, del1_s1;
	logic [W-1:0]      sb0_s1, sb1_s1;

	always_ff @(posedge clk) begin
		d_s1    <= $signed({seg_e[AXIS][W-1], seg_e[AXIS]})
			- $signed({seg_s[AXIS][W-1], seg_s[AXIS]});
		n_s1    <= $signed({plane[W-1], plane})
			- $signed({seg_s[AXIS][W-1], seg_s[AXIS]});
		del0_s1 <= $signed({seg_e[B0][W-1], seg_e[B0]})
			- $signed({seg_s[B0][W-1], seg_s[B0]});
		del1_s1 <= $signed({seg_e[B1][W-1], seg_e[B1]})
			- $signed({seg_s[B1][W-1], seg_s[B1]});
		sb0_s1  <= seg_s[B0];
		sb1_s1  <= seg_s[B1];
	end

	logic         ok_s2, sg0_s2, sg1_s2;
	logic [W-1:0] md_s2, mn_s2, mdel0_s2, mdel1_s2, sb0_s2, sb1_s2;

	always_ff @(posedge clk) begin
		ok_s2    <= (d_s1 != '0) && (d_s1[W]
			? (n_s1 <= 0 && n_s1 >= d_s1)
			: (n_s1 >= 0 && n_s1 <= d_s1));
		md_s2    <= d_s1[W] ? W'(-d_s1) : W'(d_s1);
		mn_s2    <= n_s1[W] ? W'(-n_s1) : W'(n_s1);
		mdel0_s2 <= del0_s1[W] ? W'(-del0_s1) : W'(del0_s1);
		mdel1_s2 <= del1_s1[W] ? W'(-del1_s1) : W'(del1_s1);
		sg0_s2   <= del0_s1[W];
		sg1_s2   <= del1_s1[W];
		sb0_s2   <= sb0_s1;
		sb1_s2   <= sb1_s1;
	end

	logic           ok_s3, sg0_s3, sg1_s3;
	logic [2*W-1:0] prod0_s3, prod1_s3;
	logic [W-1:0]   md_s3, mn_s3, sb0_s3, sb1_s3;

	always_ff @(posedge clk) begin
		prod0_s3 <= mdel0_s2 * mn_s2;
		prod1_s3 <= mdel1_s2 * mn_s2;
		ok_s3    <= ok_s2;
		sg0_s3   <= sg0_s2;
		sg1_s3   <= sg1_s2;
		md_s3    <= md_s2;
		mn_s3    <= mn_s2;
		sb0_s3   <= sb0_s2;
		sb1_s3   <= sb1_s2;
	end

	logic [W:0] quo0, quo1;

	sbi_div #(.W(W)) u_div0 (.clk(clk), .num(prod0_s3), .den(md_s3), .quo(quo0));
	sbi_div #(.W(W)) u_div1 (.clk(clk), .num(prod1_s3), .den(md_s3), .quo(quo1));

	// side data rides alongside the dividers
	logic [DIV_LAT-1:0] ok_d, sg0_d, sg1_d;
	logic [W-1:0]       mn_d [DIV_LAT];
	logic [W-1:0]       sb0_d [DIV_LAT];
	logic [W-1:0]       sb1_d [DIV_LAT];

	always_ff @(posedge clk) begin
		ok_d     <= {ok_d[DIV_LAT-2:0], ok_s3};
		sg0_d    <= {sg0_d[DIV_LAT-2:0], sg0_s3};
		sg1_d    <= {sg1_d[DIV_LAT-2:0], sg1_s3};
		mn_d[0]  <= mn_s3;
		sb0_d[0] <= sb0_s3;
		sb1_d[0] <= sb1_s3;
		for (int k = 1; k < DIV_LAT; k++) begin
			mn_d[k]  <= mn_d[k-1];
			sb0_d[k] <= sb0_d[k-1];
			sb1_d[k] <= sb1_d[k-1];
		end
	end

	logic         ok_s4;
	logic [W-1:0] p0_s4, p1_s4, q0_s4, q1_s4, mn_s4;

	always_ff @(posedge clk) begin
		p0_s4 <= sg0_d[DIV_LAT-1] ? sb0_d[DIV_LAT-1] - quo0[W-1:0]
			: sb0_d[DIV_LAT-1] + quo0[W-1:0];
		p1_s4 <= sg1_d[DIV_LAT-1] ? sb1_d[DIV_LAT-1] - quo1[W-1:0]
			: sb1_d[DIV_LAT-1] + quo1[W-1:0];
		q0_s4 <= quo0[W-1:0];
		q1_s4 <= quo1[W-1:0];
		mn_s4 <= mn_d[DIV_LAT-1];
		ok_s4 <= ok_d[DIV_LAT-1];
	end

	logic           ok_s5;
	logic [2*W-1:0] sqa_s5, sq0_s5, sq1_s5;
	logic [W-1:0]   p0_s5, p1_s5;

	always_ff @(posedge clk) begin
		ok_s5  <= ok_s4
			&& $signed(p0_s4) >= $signed(box_lo[B0]) && $signed(p0_s4) <= $signed(box_hi[B0])
			&& $signed(p1_s4) >= $signed(box_lo[B1]) && $signed(p1_s4) <= $signed(box_hi[B1]);
		sqa_s5 <= mn_s4 * mn_s4;
		sq0_s5 <= q0_s4 * q0_s4;
		sq1_s5 <= q1_s4 * q1_s4;
		p0_s5  <= p0_s4;
		p1_s5  <= p1_s4;
	end

	always_ff @(posedge clk) begin
		cand_ok        <= ok_s5;
		cand_dist      <= {2'b00, sqa_s5} + {2'b00, sq0_s5} + {2'b00, sq1_s5};
		cand_pnt[AXIS] <= plane;
		cand_pnt[B0]   <= p0_s5;
		cand_pnt[B1]   <= p1_s5;
	end

endmodule

`default_nettype wire

>>> hw/rtl/sbi_sel.sv
// ----------------------------------------------------------------------------
// Nearest face select
// Registered compare tree over the six face candidates; lower face wins ties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbi_sel import sbi_pkg::*; #(
	parameter int W = 32
) (
	input  logic                          clk,
	input  logic [FACE_COUNT-1:0]         cand_ok,
	input  logic [FACE_COUNT-1:0][2*W+1:0] cand_dist,
	input  logic [FACE_COUNT-1:0][2:0][W-1:0] cand_pnt,
	output logic                          hit,
	output face_t                         face,
	output logic [2:0][W-1:0]             pnt
);

	pick_t                  pk_s1 [3];
	logic [2*W+1:0]         dist_s1 [3];
	logic [2:0][W-1:0]      pnt_s1 [3];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (cand_ok[2*j+1] && (!cand_ok[2*j] || cand_dist[2*j+1] < cand_dist[2*j])) begin
				pk_s1[j]   <= '{ok: 1'b1, face: face_t'(3'(2*j+1))};
				dist_s1[j] <= cand_dist[2*j+1];
				pnt_s1[j]  <= cand_pnt[2*j+1];
			end else begin
				pk_s1[j]   <= '{ok: cand_ok[2*j], face: face_t'(3'(2*j))};
				dist_s1[j] <= cand_dist[2*j];
				pnt_s1[j]  <= cand_pnt[2*j];
			end
		end
	end

	pick_t             wpk_s2, cpk_s2;
	logic [2*W+1:0]    wdist_s2, cdist_s2;
	logic [2:0][W-1:0] wpnt_s2, cpnt_s2;

	always_ff @(posedge clk) begin
		if (pk_s1[1].ok && (!pk_s1[0].ok || dist_s1[1] < dist_s1[0])) begin
			wpk_s2   <= pk_s1[1];
			wdist_s2 <= dist_s1[1];
			wpnt_s2  <= pnt_s1[1];
		end else begin
			wpk_s2   <= pk_s1[0];
			wdist_s2 <= dist_s1[0];
			wpnt_s2  <= pnt_s1[0];
		end
		cpk_s2   <= pk_s1[2];
		cdist_s2 <= dist_s1[2];
		cpnt_s2  <= pnt_s1[2];
	end

	always_ff @(posedge clk) begin
		if (cpk_s2.ok && (!wpk_s2.ok || cdist_s2 < wdist_s2)) begin
			hit  <= 1'b1;
			face <= cpk_s2.face;
			pnt  <= cpnt_s2;
		end else if (wpk_s2.ok) begin
			hit  <= 1'b1;
			face <= wpk_s2.face;
			pnt  <= wpnt_s2;
		end else begin
			hit  <= 1'b0;
			face <= FACE_MIN_X;
			pnt  <= '0;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/segment_box_intercept_core.sv
// ----------------------------------------------------------------------------
// Segment box intercept core
// Nearest crossing of a line segment with the faces of a configured box.
// ----------------------------------------------------------------------------
// Fully pipelined: a segment can be started on every clock and busy never
// rises. The result appears on hit/face/point_* with a one-cycle done strobe;
// the pipeline depth is set by the per-face dividers, which retire one
// quotient bit per stage. The result must be captured on the done cycle.
// Box registers are written with cfg_we/cfg_idx/cfg_data; the user must
// write them only while no segment is in flight, which the block itself
// does not enforce; index 6 and 7 are ignored.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_box_intercept_core_assert.svh"

module segment_box_intercept_core import sbi_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_idx,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	output logic                          done,
	output logic                          hit,
	output logic [2:0]                    face,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [COORD_WIDTH-1:0] point_z
);

	localparam int W   = COORD_WIDTH;
	localparam int LAT = W + 11;

	logic [2:0][W-1:0] box_lo_q, box_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lo_q <= '0;
			box_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_X: box_lo_q[0] <= cfg_data;
				REG_MIN_Y: box_lo_q[1] <= cfg_data;
				REG_MIN_Z: box_lo_q[2] <= cfg_data;
				REG_MAX_X: box_hi_q[0] <= cfg_data;
				REG_MAX_Y: box_hi_q[1] <= cfg_data;
				REG_MAX_Z: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	logic [2:0][W-1:0] seg_s_s1, seg_e_s1;

	always_ff @(posedge clk) begin
		seg_s_s1 <= {start_z, start_y, start_x};
		seg_e_s1 <= {end_z, end_y, end_x};
	end

	logic [FACE_COUNT-1:0]             cand_ok;
	logic [FACE_COUNT-1:0][2*W+1:0]    cand_dist;
	logic [FACE_COUNT-1:0][2:0][W-1:0] cand_pnt;

	for (genvar f = 0; f < FACE_COUNT; f++) begin : g_face
		sbi_face #(
			.W    (W),
			.AXIS (f / 2),
			.UPPER((f % 2) == 1)
		) u_face (
			.clk      (clk),
			.seg_s    (seg_s_s1),
			.seg_e    (seg_e_s1),
			.box_lo   (box_lo_q),
			.box_hi   (box_hi_q),
			.cand_ok  (cand_ok[f]),
			.cand_dist(cand_dist[f]),
			.cand_pnt (cand_pnt[f])
		);
	end

	face_t             sel_face;
	logic [2:0][W-1:0] sel_pnt;

	sbi_sel #(.W(W)) u_sel (
		.clk      (clk),
		.cand_ok  (cand_ok),
		.cand_dist(cand_dist),
		.cand_pnt (cand_pnt),
		.hit      (hit),
		.face     (sel_face),
		.pnt      (sel_pnt)
	);

	assign done    = vld_q[LAT-1];
	assign face    = sel_face;
	assign point_x = sel_pnt[0];
	assign point_y = sel_pnt[1];
	assign point_z = sel_pnt[2];

	`SBI_ASSERT_NEVER(a_face_range, clk, arst_n, done && face > FACE_MAX_Z)
	`SBI_ASSERT_IMPL(a_miss_zero, clk, arst_n, done && !hit, face == FACE_MIN_X && point_x == '0 && point_y == '0 && point_z == '0)
	`SBI_ASSERT_IMPL(a_latency, clk, arst_n, done, $past(start, LAT))

endmodule

`default_nettype wire

>>> bench/segment_box_intercept_core_tb.sv
// ----------------------------------------------------------------------------
// Segment box intercept core testbench
// Streams segments through the core under several box settings, with random
// start gaps, and checks every result beat against a nearest-face predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_box_intercept_core_tb;
	import sbi_pkg::*;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam longint C_MIN = -64'sd2147483648;
	localparam longint C_MAX = 64'sd2147483647;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		longint s[3];
		longint e[3];
	} segment_t;

	typedef struct {
		logic hit;
		face_t face;
		logic [31:0] pt[3];
	} crossing_t;

	logic clk, arst_n, start, busy, cfg_we, done, hit;
	logic [2:0] cfg_idx, face;
	logic [31:0] cfg_data;
	logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
	logic signed [31:0] point_x, point_y, point_z;

	segment_box_intercept_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.done(done), .hit(hit), .face(face),
		.point_x(point_x), .point_y(point_y), .point_z(point_z)
	);

	longint box_lo[3], box_hi[3];
	segment_t pending_segs[$];
	segment_t cur_seg;
	crossing_t expected_crossings[$];
	bit steady;
	int errors, beats, hits, phases;

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic crossing_t nearest_crossing(input segment_t sg);
		crossing_t r;
		logic [69:0] best_d, dist_sq;
		longint p[3];
		logic [129:0] num, q;
		longint v, d, n, del;
		bit ok;
		int a;
		r.hit = 0;
		r.face = FACE_MIN_X;
		for (int i = 0; i < 3; i++) r.pt[i] = '0;
		best_d = '0;
		for (int f = 0; f < FACE_COUNT; f++) begin
			a = f / 2;
			v = f[0] ? box_hi[a] : box_lo[a];
			d = sg.e[a] - sg.s[a];
			n = v - sg.s[a];
			if (d == 0) continue;
			if (d > 0 ? (n < 0 || n > d) : (n > 0 || n < d)) continue;
			ok = 1;
			for (int i = 0; i < 3; i++) begin
				if (i == a) p[i] = v;
				else begin
					del = sg.e[i] - sg.s[i];
					num = 130'(mag(del)) * 130'(mag(n));
					q = (2 * num + 130'(mag(d))) / (2 * 130'(mag(d)));
					p[i] = del < 0 ? sg.s[i] - longint'(q) : sg.s[i] + longint'(q);
					if (p[i] < box_lo[i] || p[i] > box_hi[i]) ok = 0;
				end
			end
			if (!ok) continue;
			dist_sq = '0;
			for (int i = 0; i < 3; i++)
				dist_sq += 70'(mag(p[i] - sg.s[i])) * 70'(mag(p[i] - sg.s[i]));
			if (!r.hit || dist_sq < best_d) begin
				r.hit = 1;
				best_d = dist_sq;
				r.face = face_t'(f);
				for (int i = 0; i < 3; i++) r.pt[i] = p[i][31:0];
			end
		end
		return r;
	endfunction

	function automatic longint clamp32(input longint v);
		return v < C_MIN ? C_MIN : (v > C_MAX ? C_MAX : v);
	endfunction

	// coordinate around the box span on one axis, often right on a plane
	function automatic longint near_box(input int ax);
		longint lo, hi, w;
		int k;
		lo = box_lo[ax] < box_hi[ax] ? box_lo[ax] : box_hi[ax];
		hi = box_lo[ax] < box_hi[ax] ? box_hi[ax] : box_lo[ax];
		w = hi - lo + 16;
		k = $urandom_range(99);
		if (k < 8) return box_lo[ax];
		if (k < 16) return box_hi[ax];
		return clamp32(lo - w / 2 + longint'(({$urandom, $urandom} >> 1) % (2 * w)));
	endfunction

	function automatic longint any32();
		return longint'($signed($urandom));
	endfunction

	function automatic segment_t make_seg(input longint s0, s1, s2, e0, e1, e2);
		segment_t sg;
		sg.s = '{s0, s1, s2};
		sg.e = '{e0, e1, e2};
		return sg;
	endfunction

	task automatic queue_random(input int count);
		segment_t sg;
		int k;
		for (int j = 0; j < count; j++) begin
			k = $urandom_range(99);
			for (int i = 0; i < 3; i++) begin
				sg.s[i] = k < 80 ? near_box(i) : any32();
				sg.e[i] = k < 80 ? near_box(i) : any32();
				if (k < 80 && $urandom_range(9) == 0) sg.e[i] = sg.s[i];
			end
			pending_segs.push_back(sg);
		end
	endtask

	task automatic load_box(input longint lo[3], input longint hi[3]);
		logic [2:0] idx[8];
		longint val[8];
		idx = '{REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z,
			REG_SPARE_LO, REG_SPARE_HI};
		val = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], any32(), any32()};
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= idx[i];
			cfg_data <= val[i][31:0];
			if (i < 3) box_lo[i] = lo[i];
			else if (i < 6) box_hi[i - 3] = hi[i - 3];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		phases++;
	endtask

	task automatic drain();
		while (pending_segs.size() != 0 || start || expected_crossings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout at %0t", $time);
		$display("RESULT: ERROR");
		$finish;
	end

	// driver: one segment per beat, random start gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (start) begin
				expected_crossings.push_back(nearest_crossing(cur_seg));
				beats++;
			end
			if (pending_segs.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
				cur_seg = pending_segs.pop_front();
				start <= 1'b1;
				start_x <= cur_seg.s[0][31:0];
				start_y <= cur_seg.s[1][31:0];
				start_z <= cur_seg.s[2][31:0];
				end_x <= cur_seg.e[0][31:0];
				end_y <= cur_seg.e[1][31:0];
				end_z <= cur_seg.e[2][31:0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		crossing_t x;
		if (arst_n && done) begin
			if (expected_crossings.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				errors++;
			end else begin
				x = expected_crossings.pop_front();
				if (hit) hits++;
				if (hit !== x.hit || face !== x.face || point_x !== x.pt[0] ||
					point_y !== x.pt[1] || point_z !== x.pt[2]) begin
					$display("%0t: expected hit %0b face %0d pt %0d %0d %0d", $time, x.hit,
						x.face, $signed(x.pt[0]), $signed(x.pt[1]), $signed(x.pt[2]));
					$display("%0t: actual   hit %0b face %0d pt %0d %0d %0d", $time, hit,
						face, point_x, point_y, point_z);
					errors++;
				end
			end
		end
	end

	initial begin
		longint lo[3], hi[3];
		errors = 0; beats = 0; hits = 0; phases = 0; steady = 0;
		cfg_we = 0; cfg_idx = '0; cfg_data = '0;
		start_x = 0; start_y = 0; start_z = 0; end_x = 0; end_y = 0; end_z = 0;
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = 0;
			box_hi[i] = 0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset box: a single point at the origin
		pending_segs.push_back(make_seg(-65536, 0, 0, 65536, 0, 0));
		pending_segs.push_back(make_seg(-65536, -65536, -65536, 65536, 65536, 65536));
		queue_random(20);
		drain();

		// ordinary box, directed cases
		lo = '{-100000, -100000, -100000};
		hi = '{100000, 100000, 100000};
		load_box(lo, hi);
		pending_segs.push_back(make_seg(-200000, 0, 0, 200000, 0, 0));
		pending_segs.push_back(make_seg(200000, 0, 0, -200000, 0, 0));
		pending_segs.push_back(make_seg(0, -200000, 0, 0, 200000, 0));
		pending_segs.push_back(make_seg(0, 0, 200000, 0, 0, -200000));
		pending_segs.push_back(make_seg(0, 0, 0, 0, 0, 0));
		pending_segs.push_back(make_seg(5, 7, 9, 5, 7, 9));
		pending_segs.push_back(make_seg(-200000, -200000, -200000, 200000, 200000, 200000));
		pending_segs.push_back(make_seg(-200000, 100000, 0, 200000, 100000, 0));
		pending_segs.push_back(make_seg(-100000, 0, 0, -300000, 0, 0));
		pending_segs.push_back(make_seg(-300000, 0, 0, -100000, 0, 0));
		pending_segs.push_back(make_seg(-300000, 0, 0, -200000, 0, 0));
		pending_segs.push_back(make_seg(-200000, 300000, 0, 200000, 300000, 0));
		pending_segs.push_back(make_seg(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
		pending_segs.push_back(make_seg(C_MAX, C_MIN, 0, C_MIN, C_MAX, 1));
		pending_segs.push_back(make_seg(-200001, 3, -7, 199999, -5, 11));
		pending_segs.push_back(make_seg(-300000, 0, 0, 300000, 1, -1));
		queue_random(200);
		drain();

		// full-range box, no idling
		lo = '{C_MIN, C_MIN, C_MIN};
		hi = '{C_MAX, C_MAX, C_MAX};
		load_box(lo, hi);
		steady = 1;
		pending_segs.push_back(make_seg(C_MIN, 0, 0, C_MAX, 0, 0));
		pending_segs.push_back(make_seg(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
		pending_segs.push_back(make_seg(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN));
		queue_random(100);
		drain();
		steady = 0;

		// y axis inverted
		lo = '{-50000, 40000, -50000};
		hi = '{50000, -40000, 50000};
		load_box(lo, hi);
		pending_segs.push_back(make_seg(0, -100000, 0, 0, 100000, 0));
		pending_segs.push_back(make_seg(-100000, 0, 0, 100000, 0, 0));
		queue_random(100);
		drain();

		// random box per phase
		for (int ph = 0; ph < 2; ph++) begin
			for (int i = 0; i < 3; i++) begin
				lo[i] = any32() / 4;
				hi[i] = lo[i] + $urandom_range(1 << 20);
			end
			load_box(lo, hi);
			queue_random(60);
			drain();
		end

		$display("covered %0d segments over %0d box settings, %0d hits", beats, phases + 1,
			hits);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> segment_box_intercept_core.f
+incdir+hw/rtl
hw/rtl/sbi_pkg.sv
hw/rtl/sbi_div.sv
hw/rtl/sbi_face.sv
hw/rtl/sbi_sel.sv
hw/rtl/segment_box_intercept_core.sv
bench/segment_box_intercept_core_tb.sv
